// ===== hw/rtl/uvs_pkg.sv =====
// Shared types, constants and tables for the UV sphere vertex generator.
package uvs_pkg;

  localparam int SEG_BITS = 10;
  localparam int ANGLE_BITS = 16;
  localparam int TEX_SHIFT = 17;
  localparam int DIV_A = SEG_BITS + ANGLE_BITS + 2;
  localparam int DIV_B = SEG_BITS + TEX_SHIFT + 2;
  localparam int DIV_W = (DIV_A > DIV_B) ? DIV_A : DIV_B;
  localparam int CORDIC_STEPS = 24;
  localparam int CORD_LAT = CORDIC_STEPS + 2;
  localparam int MUL_LAT = 4;
  localparam int CW = 34;

  typedef logic [SEG_BITS-1:0] seg_t;
  typedef logic [SEG_BITS:0] rem_t;
  typedef logic [SEG_BITS+1:0] trial_t;
  typedef logic [DIV_W-1:0] div_t;
  typedef logic [ANGLE_BITS-1:0] ang_t;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [31:0] trig_t;
  typedef logic [19:0] idx_t;
  typedef logic [16:0] tex_t;
  typedef logic signed [16:0] pos_t;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_RINGS  = 2'd1,
    REG_COLS   = 2'd2,
    REG_MIRROR = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TRI_NONE = 2'd0,
    TRI_ABC  = 2'd1,
    TRI_ACD  = 2'd2,
    TRI_BOTH = 2'd3
  } tri_t;

  localparam tex_t TEX_ONE = 17'h10000;
  localparam cw_t CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [63:0] POS_LIMIT = 64'sd65535;

  localparam logic [31:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    idx_t corner_a;
    idx_t corner_b;
    idx_t corner_c;
    idx_t corner_d;
    tri_t tri_kind;
    logic out_of_range;
  } sb_t;

  typedef struct packed {
    tex_t tex_u;
    tex_t tex_v;
  } uv_t;

  function automatic pos_t sat_pos(input logic signed [63:0] v);
    pos_t r;
    if (v > POS_LIMIT) begin
      r = pos_t'(POS_LIMIT);
    end else if (v < -POS_LIMIT) begin
      r = pos_t'(-POS_LIMIT);
    end else begin
      r = pos_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/uvs_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module uvs_divider (
  input  logic          clk,
  input  logic          en,
  input  uvs_pkg::div_t num,
  input  uvs_pkg::rem_t den,
  output uvs_pkg::div_t quo
);

  uvs_pkg::rem_t  rem_q [uvs_pkg::DIV_W];
  uvs_pkg::div_t  num_q [uvs_pkg::DIV_W];
  uvs_pkg::div_t  quo_q [uvs_pkg::DIV_W];
  uvs_pkg::rem_t  rem_next [uvs_pkg::DIV_W];
  uvs_pkg::div_t  num_next [uvs_pkg::DIV_W];
  uvs_pkg::div_t  quo_next [uvs_pkg::DIV_W];
  uvs_pkg::trial_t trial [uvs_pkg::DIV_W];

  always_comb begin
    for (int k = 0; k < uvs_pkg::DIV_W; k++) begin
      uvs_pkg::rem_t r;
      uvs_pkg::div_t n;
      uvs_pkg::div_t q;
      if (k == 0) begin
        r = '0;
        n = num;
        q = '0;
      end else begin
        r = rem_q[k-1];
        n = num_q[k-1];
        q = quo_q[k-1];
      end
      trial[k] = {r, n[uvs_pkg::DIV_W-1]};
      num_next[k] = {n[uvs_pkg::DIV_W-2:0], 1'b0};
      if (trial[k] >= {1'b0, den}) begin
        rem_next[k] = uvs_pkg::rem_t'(trial[k] - {1'b0, den});
        quo_next[k] = {q[uvs_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_next[k] = uvs_pkg::rem_t'(trial[k]);
        quo_next[k] = {q[uvs_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < uvs_pkg::DIV_W; k++) begin
        rem_q[k] <= rem_next[k];
        num_q[k] <= num_next[k];
        quo_q[k] <= quo_next[k];
      end
    end
  end

  assign quo = quo_q[uvs_pkg::DIV_W-1];

endmodule

// ===== hw/rtl/uvs_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of a turn fraction.
module uvs_cordic (
  input  logic          clk,
  input  logic          en,
  input  uvs_pkg::ang_t ang,
  output uvs_pkg::trig_t sin_o,
  output uvs_pkg::trig_t cos_o
);

  localparam int N = uvs_pkg::CORDIC_STEPS;

  uvs_pkg::cw_t x_q [N+1];
  uvs_pkg::cw_t y_q [N+1];
  uvs_pkg::cw_t z_q [N+1];
  logic         flip_q [N+1];
  uvs_pkg::trig_t sin_q;
  uvs_pkg::trig_t cos_q;

  logic [31:0] t_full;
  logic        flip_in;
  logic [31:0] t_fold;

  assign t_full = {ang, {(32 - uvs_pkg::ANGLE_BITS){1'b0}}};
  assign flip_in = t_full[31] ^ t_full[30];
  assign t_fold = {t_full[31] ^ flip_in, t_full[30:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0] <= uvs_pkg::CORDIC_GAIN_INV;
      y_q[0] <= '0;
      z_q[0] <= uvs_pkg::cw_t'($signed(t_fold));
      flip_q[0] <= flip_in;
      for (int i = 0; i < N; i++) begin
        if (!z_q[i][uvs_pkg::CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - uvs_pkg::cw_t'(uvs_pkg::ATAN_TBL[i]);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + uvs_pkg::cw_t'(uvs_pkg::ATAN_TBL[i]);
        end
        flip_q[i+1] <= flip_q[i];
      end
      if (flip_q[N]) begin
        cos_q <= uvs_pkg::trig_t'(-x_q[N]);
        sin_q <= uvs_pkg::trig_t'(-y_q[N]);
      end else begin
        cos_q <= uvs_pkg::trig_t'(x_q[N]);
        sin_q <= uvs_pkg::trig_t'(y_q[N]);
      end
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator_unit.sv =====
// Top level of the UV sphere vertex generator.
// Usage: each slave transaction carries one grid point (ring, column); each
// master transaction returns its vertex position, texture coordinate, corner
// indices, triangle kind and range flag, in input order, one result per input.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register
// per cycle; the user must write it only while no point is in flight, as the
// block itself does not enforce this. Throughput is one point per cycle while
// m_tready does not stall the pipeline. On its way to the master side a point
// passes the input register, which loads at the accepting edge, then one
// restoring divider stage per quotient bit, two CORDIC setup/fold stages plus
// one per rotation, and four multiply, round and saturate stages.
// All stages advance together; when the receiver holds m_tready low with a
// result pending, the whole pipeline and s_tready stall, and nothing is lost or
// repeated. Bubbles in the input stream travel as invalid slots.
// Reset clears all valid bits and loads radius 256, 16 rings, 32 columns and
// no mirroring.
module uv_sphere_vertex_generator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // ring[9:0], column[19:10], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, corner_a..d, pad
  output logic [2:0]   m_tuser,   // tri_kind[1:0], out_of_range[2]
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int SEG = uvs_pkg::SEG_BITS;
  localparam int TOT = uvs_pkg::DIV_W + uvs_pkg::CORD_LAT + uvs_pkg::MUL_LAT;
  localparam int UV_N = uvs_pkg::CORD_LAT + uvs_pkg::MUL_LAT - 1;

  logic [15:0]  radius;
  uvs_pkg::seg_t ring_count;
  uvs_pkg::seg_t column_count;
  logic         tex_mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      ring_count <= uvs_pkg::seg_t'(16);
      column_count <= uvs_pkg::seg_t'(32);
      tex_mirror <= 1'b0;
    end else if (cfg_we) begin
      case (uvs_pkg::cfg_reg_t'(cfg_index))
        uvs_pkg::REG_RADIUS: radius <= cfg_data;
        uvs_pkg::REG_RINGS:  ring_count <= cfg_data[SEG-1:0];
        uvs_pkg::REG_COLS:   column_count <= cfg_data[SEG-1:0];
        uvs_pkg::REG_MIRROR: tex_mirror <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic s0_vld;
  uvs_pkg::seg_t s0_ring;
  uvs_pkg::seg_t s0_col;
  logic p_vld [TOT];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      for (int j = 0; j < TOT; j++) begin
        p_vld[j] <= 1'b0;
      end
    end else if (en) begin
      s0_vld <= s_tvalid;
      p_vld[0] <= s0_vld;
      for (int j = 1; j < TOT; j++) begin
        p_vld[j] <= p_vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ring <= s_tdata[SEG-1:0];
      s0_col <= s_tdata[10+SEG-1:10];
    end
  end

  uvs_pkg::seg_t rings_c;
  uvs_pkg::seg_t cols_c;
  uvs_pkg::seg_t rc;
  uvs_pkg::seg_t cc;
  logic          oor_c;
  logic [SEG:0]  colsp1;
  logic [2*SEG:0] a_mul;
  uvs_pkg::idx_t a_c;
  uvs_pkg::sb_t  sb_c;
  uvs_pkg::div_t n_va, n_ha, n_u, n_v;
  uvs_pkg::rem_t den_r, den_c;

  always_comb begin
    rings_c = (ring_count == '0) ? uvs_pkg::seg_t'(1) : ring_count;
    cols_c = (column_count == '0) ? uvs_pkg::seg_t'(1) : column_count;
    oor_c = (s0_ring > rings_c) || (s0_col > cols_c);
    rc = (s0_ring > rings_c) ? rings_c : s0_ring;
    cc = (s0_col > cols_c) ? cols_c : s0_col;
    colsp1 = {1'b0, cols_c} + (SEG+1)'(1);
    a_mul = colsp1 * s0_ring;
    a_c = uvs_pkg::idx_t'(a_mul + (2*SEG+1)'(s0_col));
    sb_c.corner_a = a_c;
    sb_c.corner_b = '0;
    sb_c.corner_c = '0;
    sb_c.corner_d = '0;
    sb_c.tri_kind = uvs_pkg::TRI_NONE;
    sb_c.out_of_range = oor_c;
    if (s0_ring != '0 && s0_col != '0) begin
      sb_c.corner_b = a_c - uvs_pkg::idx_t'(1);
      sb_c.corner_c = a_c - uvs_pkg::idx_t'(cols_c) - uvs_pkg::idx_t'(2);
      sb_c.corner_d = a_c - uvs_pkg::idx_t'(cols_c) - uvs_pkg::idx_t'(1);
      if (!oor_c) begin
        if (s0_ring == rings_c) begin
          sb_c.tri_kind = uvs_pkg::TRI_ACD;
        end else if (s0_ring == uvs_pkg::seg_t'(1)) begin
          sb_c.tri_kind = uvs_pkg::TRI_ABC;
        end else begin
          sb_c.tri_kind = uvs_pkg::TRI_BOTH;
        end
      end
    end
    den_r = {rings_c, 1'b0};
    den_c = {cols_c, 1'b0};
    n_va = uvs_pkg::div_t'({s0_ring, {uvs_pkg::ANGLE_BITS{1'b0}}}) +
           uvs_pkg::div_t'(rings_c);
    n_ha = uvs_pkg::div_t'({s0_col, {(uvs_pkg::ANGLE_BITS+1){1'b0}}}) +
           uvs_pkg::div_t'(cols_c);
    n_u = uvs_pkg::div_t'({uvs_pkg::seg_t'(cols_c - cc), {uvs_pkg::TEX_SHIFT{1'b0}}}) +
          uvs_pkg::div_t'(cols_c);
    n_v = uvs_pkg::div_t'({rc, {uvs_pkg::TEX_SHIFT{1'b0}}}) + uvs_pkg::div_t'(rings_c);
  end

  uvs_pkg::div_t q_va, q_ha, q_u, q_v;

  uvs_divider u_div_va (.clk(clk), .en(en), .num(n_va), .den(den_r), .quo(q_va));
  uvs_divider u_div_ha (.clk(clk), .en(en), .num(n_ha), .den(den_c), .quo(q_ha));
  uvs_divider u_div_u  (.clk(clk), .en(en), .num(n_u),  .den(den_c), .quo(q_u));
  uvs_divider u_div_v  (.clk(clk), .en(en), .num(n_v),  .den(den_r), .quo(q_v));

  uvs_pkg::sb_t sb_q [TOT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_q[0] <= sb_c;
      for (int j = 1; j < TOT-1; j++) begin
        sb_q[j] <= sb_q[j-1];
      end
    end
  end

  uvs_pkg::uv_t uv_c;
  uvs_pkg::uv_t uv_q [UV_N];

  always_comb begin
    uv_c.tex_u = q_u[16:0];
    uv_c.tex_v = q_v[16:0];
    if (tex_mirror) begin
      uv_c.tex_u = uvs_pkg::tex_t'(uvs_pkg::TEX_ONE - q_u[16:0]);
      uv_c.tex_v = uvs_pkg::tex_t'(uvs_pkg::TEX_ONE - q_v[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uv_q[0] <= uv_c;
      for (int j = 1; j < UV_N; j++) begin
        uv_q[j] <= uv_q[j-1];
      end
    end
  end

  uvs_pkg::trig_t vsin, vcos, hsin, hcos;

  uvs_cordic u_cordic_v (
    .clk(clk), .en(en), .ang(q_va[uvs_pkg::ANGLE_BITS-1:0]), .sin_o(vsin), .cos_o(vcos)
  );
  uvs_cordic u_cordic_h (
    .clk(clk), .en(en), .ang(q_ha[uvs_pkg::ANGLE_BITS-1:0]), .sin_o(hsin), .cos_o(hcos)
  );

  logic signed [48:0] m1_py, m1_pr;
  uvs_pkg::trig_t     m1_ch, m1_sh;
  uvs_pkg::pos_t      m2_py;
  uvs_pkg::trig_t     m2_rr, m2_ch, m2_sh;
  logic signed [63:0] m3_px, m3_pz;
  uvs_pkg::pos_t      m3_py;
  logic signed [48:0] py_rnd, rr_rnd;
  logic signed [63:0] px_rnd, pz_rnd;

  assign py_rnd = (m1_py + (49'sd1 <<< 29)) >>> 30;
  assign rr_rnd = (m1_pr + (49'sd1 <<< 15)) >>> 16;
  assign px_rnd = (m3_px + (64'sd1 <<< 43)) >>> 44;
  assign pz_rnd = (m3_pz + (64'sd1 <<< 43)) >>> 44;

  uvs_pkg::pos_t o_x, o_y, o_z;
  uvs_pkg::uv_t  o_uv;
  uvs_pkg::sb_t  o_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_py <= $signed({1'b0, radius}) * vcos;
      m1_pr <= $signed({1'b0, radius}) * vsin;
      m1_ch <= hcos;
      m1_sh <= hsin;
      m2_py <= uvs_pkg::sat_pos(64'(py_rnd));
      m2_rr <= uvs_pkg::trig_t'(rr_rnd);
      m2_ch <= m1_ch;
      m2_sh <= m1_sh;
      m3_px <= m2_rr * m2_ch;
      m3_pz <= m2_rr * m2_sh;
      m3_py <= m2_py;
      o_x <= uvs_pkg::sat_pos(px_rnd);
      o_z <= uvs_pkg::sat_pos(pz_rnd);
      o_y <= m3_py;
      o_uv <= uv_q[UV_N-1];
      o_sb <= sb_q[TOT-2];
    end
  end

  assign m_tvalid = p_vld[TOT-1];
  assign m_tdata = {3'b000, o_sb.corner_d, o_sb.corner_c, o_sb.corner_b, o_sb.corner_a,
                    o_uv.tex_v, o_uv.tex_u, o_z, o_y, o_x};
  assign m_tuser = {o_sb.out_of_range, o_sb.tri_kind};

endmodule
